// ===== hdl/nlm_pkg.sv =====
// Package for the nearest location match unit: types, constants and codes.
// Depends on nothing; used by every module of the block.
package nlm_pkg;

    localparam int Capacity = 1024;
    localparam int AddrW = $clog2(Capacity);
    localparam int CountW = $clog2(Capacity + 1);
    localparam int CoordW = 30;
    localparam int DiffW = 31;
    localparam int SqW = 62;
    localparam int SumW = 63;
    localparam int DistW = 31;
    localparam int LinkW = 20;
    localparam int IndexW = 21;
    localparam int SqrtSteps = 32;
    localparam int StepW = $clog2(SqrtSteps + 1);

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_LINK = 2'd1;
    localparam logic [1:0] KIND_OTHER = 2'd2;

    localparam logic [1:0] REG_MAX_DISTANCE = 2'd0;
    localparam logic [1:0] REG_NEAR_ENOUGH = 2'd1;
    localparam logic [1:0] REG_INDEX_BASE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIFF,
        ST_SQUARE,
        ST_SQRT,
        ST_UPDATE,
        ST_REPORT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clear;
        logic capture_query;
        logic read_cand;
        logic calc_diff;
        logic calc_square;
        logic sqrt_init;
        logic sqrt_step;
        logic update;
        logic report;
    } cmd_t;

    // Status back to the controller.
    typedef struct packed {
        logic scan_done;
        logic sqrt_done;
        logic stop_early;
    } status_t;

endpackage

// ===== hdl/nearest_location_match_unit.sv =====
// Top level of the nearest location match unit.
// Depends on nlm_pkg, nlm_ctrl and nlm_datapath.
//
// Loads and clears do not raise busy. A query scans the stored candidates in load
// order, each through a memory read, difference, square, 32 square-root steps
// of the one-bit-per-cycle root unit, a state that sees the root finish and an update,
// then reports, and ends early on a close same-link hit. The result beat appears
// on done for one cycle and must be taken then; the receiver cannot stall it.
// busy is high while a query runs.
module nearest_location_match_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    output logic                              done,
    input  logic [1:0]                        op,
    input  logic signed [nlm_pkg::CoordW-1:0] pos_x,
    input  logic signed [nlm_pkg::CoordW-1:0] pos_y,
    input  logic [nlm_pkg::LinkW-1:0]         link_id,
    input  logic                              direction,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [nlm_pkg::DistW-1:0]         cfg_data,
    output logic [1:0]                        match_kind,
    output logic [nlm_pkg::IndexW-1:0]        match_index,
    output logic [nlm_pkg::DistW-1:0]         match_distance
);

    nlm_pkg::cmd_t cmd;
    nlm_pkg::status_t status;
    logic [nlm_pkg::DistW-1:0] max_distance_reg, near_enough_reg;
    logic [nlm_pkg::IndexW-1:0] index_base_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_distance_reg <= '1;
            near_enough_reg <= nlm_pkg::DistW'(50);
            index_base_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                nlm_pkg::REG_MAX_DISTANCE: max_distance_reg <= cfg_data;
                nlm_pkg::REG_NEAR_ENOUGH: near_enough_reg <= cfg_data;
                nlm_pkg::REG_INDEX_BASE: index_base_reg <= cfg_data[nlm_pkg::IndexW-1:0];
                default: ;
            endcase
        end
    end

    nlm_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    nlm_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .link_id        (link_id),
        .direction      (direction),
        .max_distance   (max_distance_reg),
        .near_enough    (near_enough_reg),
        .index_base     (index_base_reg),
        .result_valid   (done),
        .match_kind     (match_kind),
        .match_index    (match_index),
        .match_distance (match_distance)
    );

endmodule

// ===== hdl/nlm_ctrl.sv =====
// Controller state machine of the nearest location match unit.
// Depends on nlm_pkg.
module nlm_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          op,
    input  nlm_pkg::status_t    status,
    output logic                busy,
    output nlm_pkg::cmd_t       cmd
);

    nlm_pkg::state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nlm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = (state_reg != nlm_pkg::ST_IDLE);
        unique case (state_reg)
            nlm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    // The unused op code is taken and dropped.
                    unique case (op)
                        nlm_pkg::OP_LOAD:
                        begin
                            cmd.load = 1'b1;
                        end
                        nlm_pkg::OP_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        nlm_pkg::OP_QUERY:
                        begin
                            cmd.capture_query = 1'b1;
                            state_next = nlm_pkg::ST_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            nlm_pkg::ST_READ:
            begin
                if (status.scan_done)
                begin
                    state_next = nlm_pkg::ST_REPORT;
                end
                else
                begin
                    cmd.read_cand = 1'b1;
                    state_next = nlm_pkg::ST_DIFF;
                end
            end
            nlm_pkg::ST_DIFF:
            begin
                cmd.calc_diff = 1'b1;
                state_next = nlm_pkg::ST_SQUARE;
            end
            nlm_pkg::ST_SQUARE:
            begin
                cmd.calc_square = 1'b1;
                state_next = nlm_pkg::ST_SQRT;
            end
            nlm_pkg::ST_SQRT:
            begin
                if (status.sqrt_done)
                begin
                    state_next = nlm_pkg::ST_UPDATE;
                end
                else
                begin
                    cmd.sqrt_step = 1'b1;
                end
            end
            nlm_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = status.stop_early ? nlm_pkg::ST_REPORT : nlm_pkg::ST_READ;
            end
            nlm_pkg::ST_REPORT:
            begin
                cmd.report = 1'b1;
                state_next = nlm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = nlm_pkg::ST_IDLE;
            end
        endcase
        cmd.sqrt_init = cmd.calc_square;
    end

    // Assertions.
    a_report_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nlm_pkg::ST_REPORT) |=> (state_reg == nlm_pkg::ST_IDLE))
        else $error("report did not return to idle");
    a_query_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nlm_pkg::ST_IDLE && start && op == nlm_pkg::OP_QUERY)
        |=> (state_reg == nlm_pkg::ST_READ))
        else $error("query did not start a scan");
    a_one_hot_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.clear, cmd.capture_query, cmd.read_cand,
                  cmd.calc_diff, cmd.sqrt_step, cmd.update, cmd.report}))
        else $error("overlapping commands");

endmodule

// ===== hdl/nlm_datapath.sv =====
// Datapath of the nearest location match unit: candidate memories, distance
// arithmetic, bit-serial square root and best-match registers. Depends on nlm_pkg.
module nlm_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  nlm_pkg::cmd_t                   cmd,
    output nlm_pkg::status_t                status,
    input  logic signed [nlm_pkg::CoordW-1:0] pos_x,
    input  logic signed [nlm_pkg::CoordW-1:0] pos_y,
    input  logic [nlm_pkg::LinkW-1:0]       link_id,
    input  logic                            direction,
    input  logic [nlm_pkg::DistW-1:0]       max_distance,
    input  logic [nlm_pkg::DistW-1:0]       near_enough,
    input  logic [nlm_pkg::IndexW-1:0]      index_base,
    output logic                            result_valid,
    output logic [1:0]                      match_kind,
    output logic [nlm_pkg::IndexW-1:0]      match_index,
    output logic [nlm_pkg::DistW-1:0]       match_distance
);

    // Candidate store.
    logic signed [nlm_pkg::CoordW-1:0] mem_x [nlm_pkg::Capacity];
    logic signed [nlm_pkg::CoordW-1:0] mem_y [nlm_pkg::Capacity];
    logic [nlm_pkg::LinkW:0]           mem_ld [nlm_pkg::Capacity];

    logic [nlm_pkg::CountW-1:0] count_reg;
    logic [nlm_pkg::CountW-1:0] scan_reg;
    logic [nlm_pkg::AddrW-1:0]  pos_reg;

    logic signed [nlm_pkg::CoordW-1:0] qx_reg, qy_reg, cx_reg, cy_reg;
    logic [nlm_pkg::LinkW:0] qld_reg, cld_reg;
    logic [nlm_pkg::DiffW-1:0] ax_reg, ay_reg;
    logic [nlm_pkg::SumW-1:0] rem_reg;
    logic [nlm_pkg::SumW-1:0] root_reg;
    logic [nlm_pkg::StepW-1:0] step_reg;

    logic link_found_reg, other_found_reg, stop_reg;
    logic [nlm_pkg::AddrW-1:0] link_pos_reg, other_pos_reg;
    logic [nlm_pkg::DistW-1:0] link_d_reg, other_d_reg;

    logic signed [nlm_pkg::DiffW-1:0] dx, dy;
    logic [nlm_pkg::SumW-1:0] bit_val, trial;
    logic [nlm_pkg::DistW-1:0] cur_dist;
    logic same;

    // Writes and registered reads of the candidate store.
    always_ff @(posedge clk)
    begin
        if (cmd.load && count_reg < nlm_pkg::CountW'(nlm_pkg::Capacity))
        begin
            mem_x[count_reg[nlm_pkg::AddrW-1:0]] <= pos_x;
            mem_y[count_reg[nlm_pkg::AddrW-1:0]] <= pos_y;
            mem_ld[count_reg[nlm_pkg::AddrW-1:0]] <= {link_id, direction};
        end
        if (cmd.read_cand)
        begin
            cx_reg <= mem_x[scan_reg[nlm_pkg::AddrW-1:0]];
            cy_reg <= mem_y[scan_reg[nlm_pkg::AddrW-1:0]];
            cld_reg <= mem_ld[scan_reg[nlm_pkg::AddrW-1:0]];
        end
    end

    // Fill count and scan position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            scan_reg <= '0;
            stop_reg <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= cmd.report;
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.load && count_reg < nlm_pkg::CountW'(nlm_pkg::Capacity))
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.capture_query)
            begin
                scan_reg <= '0;
                stop_reg <= 1'b0;
            end
            else if (cmd.read_cand)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.update)
            begin
                stop_reg <= status.stop_early;
            end
        end
    end

    assign dx = nlm_pkg::DiffW'(qx_reg) - nlm_pkg::DiffW'(cx_reg);
    assign dy = nlm_pkg::DiffW'(qy_reg) - nlm_pkg::DiffW'(cy_reg);

    // Square root: one result bit per cycle, bit_val = 4^(31-step).
    assign bit_val = nlm_pkg::SumW'(1) << (7'd62 - {step_reg, 1'b0});
    assign trial = root_reg + bit_val;
    assign cur_dist = root_reg[nlm_pkg::DistW-1:0];
    assign same = (cld_reg == qld_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture_query)
        begin
            qx_reg <= pos_x;
            qy_reg <= pos_y;
            qld_reg <= {link_id, direction};
        end
        if (cmd.read_cand)
        begin
            pos_reg <= scan_reg[nlm_pkg::AddrW-1:0];
        end
        if (cmd.calc_diff)
        begin
            ax_reg <= dx[nlm_pkg::DiffW-1] ? nlm_pkg::DiffW'(-dx) : nlm_pkg::DiffW'(dx);
            ay_reg <= dy[nlm_pkg::DiffW-1] ? nlm_pkg::DiffW'(-dy) : nlm_pkg::DiffW'(dy);
        end
        if (cmd.calc_square)
        begin
            rem_reg <= nlm_pkg::SumW'(ax_reg * ax_reg) + nlm_pkg::SumW'(ay_reg * ay_reg);
            root_reg <= '0;
            step_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_val;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            step_reg <= step_reg + 1'b1;
        end
    end

    // Best-match bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_found_reg <= 1'b0;
            other_found_reg <= 1'b0;
        end
        else if (cmd.capture_query)
        begin
            link_found_reg <= 1'b0;
            other_found_reg <= 1'b0;
        end
        else if (cmd.update && cur_dist <= max_distance)
        begin
            if (same)
            begin
                if (!link_found_reg || cur_dist < link_d_reg)
                begin
                    link_found_reg <= 1'b1;
                end
            end
            else if (!other_found_reg || cur_dist < other_d_reg)
            begin
                other_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update && cur_dist <= max_distance)
        begin
            if (same)
            begin
                if (!link_found_reg || cur_dist < link_d_reg)
                begin
                    link_pos_reg <= pos_reg;
                    link_d_reg <= cur_dist;
                end
            end
            else if (!other_found_reg || cur_dist < other_d_reg)
            begin
                other_pos_reg <= pos_reg;
                other_d_reg <= cur_dist;
            end
        end
        if (cmd.report)
        begin
            priority if (link_found_reg)
            begin
                match_kind <= nlm_pkg::KIND_LINK;
                match_index <= index_base + nlm_pkg::IndexW'(link_pos_reg);
                match_distance <= link_d_reg;
            end
            else if (other_found_reg)
            begin
                match_kind <= nlm_pkg::KIND_OTHER;
                match_index <= index_base + nlm_pkg::IndexW'(other_pos_reg);
                match_distance <= other_d_reg;
            end
            else
            begin
                match_kind <= nlm_pkg::KIND_NONE;
                match_index <= '0;
                match_distance <= '0;
            end
        end
    end

    assign status.scan_done = stop_reg || (scan_reg >= count_reg);
    assign status.sqrt_done = (step_reg == nlm_pkg::StepW'(nlm_pkg::SqrtSteps));
    assign status.stop_early = (cur_dist <= max_distance) && same
        && (!link_found_reg || cur_dist < link_d_reg) && (cur_dist < near_enough);

    // Assertions.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= nlm_pkg::CountW'(nlm_pkg::Capacity))
        else $error("fill count beyond capacity");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read_cand |-> (scan_reg < count_reg))
        else $error("read beyond filled entries");
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && match_kind == nlm_pkg::KIND_NONE) |-> (match_distance == '0))
        else $error("empty result with nonzero distance");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the nearest location match unit.
// Depends on nlm_pkg and nearest_location_match_unit; holds its own candidate-store predictor.
module testbench;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CycleLimit = 4000000;
    localparam logic [30:0] DistMax = 31'h7FFFFFFF;

    typedef struct {
        logic [1:0]         op;
        logic signed [29:0] x;
        logic signed [29:0] y;
        logic [19:0]        link;
        logic               dir;
    } beat_t;

    typedef struct {
        logic [1:0]  kind;
        logic [20:0] index;
        logic [30:0] distance;
    } match_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        done;
    logic [1:0]  op = nlm_pkg::OP_LOAD;
    logic signed [nlm_pkg::CoordW-1:0] pos_x = '0;
    logic signed [nlm_pkg::CoordW-1:0] pos_y = '0;
    logic [nlm_pkg::LinkW-1:0] link_id = '0;
    logic        direction = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = nlm_pkg::REG_MAX_DISTANCE;
    logic [nlm_pkg::DistW-1:0] cfg_data = '0;
    logic [1:0]  match_kind;
    logic [nlm_pkg::IndexW-1:0] match_index;
    logic [nlm_pkg::DistW-1:0] match_distance;

    // Predictor copy of the block state.
    logic signed [29:0] store_x [nlm_pkg::Capacity];
    logic signed [29:0] store_y [nlm_pkg::Capacity];
    logic [19:0]        store_link [nlm_pkg::Capacity];
    logic               store_dir [nlm_pkg::Capacity];
    int                 store_count = 0;
    logic [30:0]        max_dist_reg = DistMax;
    logic [30:0]        near_reg = 31'd50;
    logic [20:0]        base_reg = '0;

    match_t pending_matches[$];
    int     error_count = 0;
    int     match_count = 0;
    int     beat_count = 0;
    int     query_count = 0;
    int     cycle_count = 0;
    int     idle_pct = 0;

    nearest_location_match_unit u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .op(op), .pos_x(pos_x), .pos_y(pos_y), .link_id(link_id),
        .direction(direction), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .match_kind(match_kind), .match_index(match_index),
        .match_distance(match_distance)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Floor of the square root, one result bit at a time from the top.
    function automatic logic [31:0] floor_root(input logic [63:0] n);
        logic [31:0] r;
        logic [31:0] trial;
        r = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = r | (32'd1 << b);
            if ({32'd0, trial} * {32'd0, trial} <= n)
                r = trial;
        end
        return r;
    endfunction

    // Scan the predicted store for one query point.
    function automatic match_t nearest_match(input beat_t q);
        match_t m;
        logic link_hit, other_hit;
        int link_pos, other_pos;
        logic [31:0] link_d, other_d, d;
        longint dx, dy;
        logic [63:0] sq;
        link_hit = 0; other_hit = 0;
        link_pos = 0; other_pos = 0;
        link_d = 0; other_d = 0;
        for (int i = 0; i < store_count; i++)
        begin
            dx = longint'(q.x) - longint'(store_x[i]);
            dy = longint'(q.y) - longint'(store_y[i]);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            sq = 64'(dx * dx) + 64'(dy * dy);
            d = floor_root(sq);
            if (d > {1'b0, max_dist_reg})
                continue;
            if (store_link[i] == q.link && store_dir[i] == q.dir)
            begin
                if (!link_hit || d < link_d)
                begin
                    link_hit = 1; link_pos = i; link_d = d;
                    if (d < {1'b0, near_reg})
                        break;
                end
            end
            else if (!other_hit || d < other_d)
            begin
                other_hit = 1; other_pos = i; other_d = d;
            end
        end
        if (link_hit)
        begin
            m.kind = nlm_pkg::KIND_LINK;
            m.index = 21'(base_reg + link_pos);
            m.distance = link_d[30:0];
        end
        else if (other_hit)
        begin
            m.kind = nlm_pkg::KIND_OTHER;
            m.index = 21'(base_reg + other_pos);
            m.distance = other_d[30:0];
        end
        else
        begin
            m.kind = nlm_pkg::KIND_NONE; m.index = '0; m.distance = '0;
        end
        return m;
    endfunction

    // Update the predictor for one accepted beat.
    function automatic void predict_beat(input beat_t b);
        case (b.op)
            nlm_pkg::OP_LOAD:
                if (store_count < nlm_pkg::Capacity)
                begin
                    store_x[store_count] = b.x;
                    store_y[store_count] = b.y;
                    store_link[store_count] = b.link;
                    store_dir[store_count] = b.dir;
                    store_count++;
                end
            nlm_pkg::OP_CLEAR: store_count = 0;
            nlm_pkg::OP_QUERY:
            begin
                pending_matches.push_back(nearest_match(b));
                query_count++;
            end
            default: ;
        endcase
    endfunction

    // Send one beat; start stays high when no gap follows.
    task automatic send_beat(input beat_t b);
        int gap;
        start <= 1'b1;
        op <= b.op;
        pos_x <= b.x;
        pos_y <= b.y;
        link_id <= b.link;
        direction <= b.dir;
        do @(posedge clk); while (busy);
        predict_beat(b);
        beat_count++;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send(input logic [1:0] o, input int x, input int y,
                        input int lk, input int d);
        beat_t b;
        b.op = o; b.x = 30'(x); b.y = 30'(y); b.link = 20'(lk); b.dir = d[0];
        send_beat(b);
    endtask

    // Wait until the block is idle and every match has arrived.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_matches.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register write; the enable drops between writes.
    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            nlm_pkg::REG_MAX_DISTANCE: max_dist_reg = val;
            nlm_pkg::REG_NEAR_ENOUGH: near_reg = val;
            nlm_pkg::REG_INDEX_BASE: base_reg = val[20:0];
            default: ;
        endcase
    endtask

    // Compare each match beat against the oldest prediction.
    always @(posedge clk)
    begin
        match_t e;
        if (rst_n && done)
        begin
            if (pending_matches.size() == 0)
                report("match beat with no query waiting");
            else
            begin
                e = pending_matches.pop_front();
                match_count++;
                if (match_kind !== e.kind)
                    report($sformatf("kind %0d, want %0d", match_kind, e.kind));
                if (match_index !== e.index)
                    report($sformatf("index %0d, want %0d", match_index, e.index));
                if (match_distance !== e.distance)
                    report($sformatf("distance %0d, want %0d", match_distance,
                                     e.distance));
            end
        end
    end

    // Empty store, unused op code, and the coordinate and link extremes.
    task automatic test_directed();
        send(nlm_pkg::OP_QUERY, 0, 0, 0, 0);
        send(OP_UNUSED, 5, 5, 3, 1);
        send(nlm_pkg::OP_QUERY, -536870912, 536870911, 1048575, 1);
        send(nlm_pkg::OP_LOAD, -536870912, -536870912, 1048575, 1);
        send(nlm_pkg::OP_LOAD, 536870911, 536870911, 0, 0);
        send(nlm_pkg::OP_QUERY, 536870911, -536870912, 7, 0);
        send(nlm_pkg::OP_QUERY, -536870912, -536870912, 1048575, 1);
        send(nlm_pkg::OP_CLEAR, 0, 0, 0, 0);
        send(nlm_pkg::OP_QUERY, 1, 1, 0, 0);
        // Ties between equal distances, and early stop on a near same-link hit.
        send(nlm_pkg::OP_LOAD, 100, 0, 9, 0);
        send(nlm_pkg::OP_LOAD, -100, 0, 9, 0);
        send(nlm_pkg::OP_LOAD, 0, 100, 4, 1);
        send(nlm_pkg::OP_LOAD, 0, -100, 4, 1);
        send(nlm_pkg::OP_LOAD, 10, 10, 9, 0);
        send(nlm_pkg::OP_LOAD, 1, 1, 9, 0);
        send(nlm_pkg::OP_QUERY, 0, 0, 9, 0);
        send(nlm_pkg::OP_QUERY, 0, 0, 4, 1);
        send(nlm_pkg::OP_QUERY, 0, 0, 5, 1);
        send(nlm_pkg::OP_QUERY, 3, 4, 9, 1);
        settle();
        write_reg(nlm_pkg::REG_MAX_DISTANCE, 31'd99);
        write_reg(nlm_pkg::REG_NEAR_ENOUGH, 31'd0);
        write_reg(nlm_pkg::REG_INDEX_BASE, 31'd1048576);
        send(nlm_pkg::OP_QUERY, 0, 0, 9, 0);
        send(nlm_pkg::OP_QUERY, 0, 0, 4, 1);
        send(nlm_pkg::OP_QUERY, 500, 500, 9, 0);
        settle();
        write_reg(nlm_pkg::REG_MAX_DISTANCE, 31'd0);
        write_reg(nlm_pkg::REG_NEAR_ENOUGH, DistMax);
        send(nlm_pkg::OP_QUERY, 1, 1, 9, 0);
        send(nlm_pkg::OP_QUERY, 1, 1, 2, 0);
        settle();
    endtask

    // Fill the store to capacity, then one load too many.
    task automatic test_full_store();
        write_reg(nlm_pkg::REG_MAX_DISTANCE, DistMax);
        write_reg(nlm_pkg::REG_NEAR_ENOUGH, 31'd0);
        write_reg(nlm_pkg::REG_INDEX_BASE, 31'd1048000);
        send(nlm_pkg::OP_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i <= nlm_pkg::Capacity; i++)
            send(nlm_pkg::OP_LOAD, 1000 - i, i * 3, i % 5, i % 2);
        send(nlm_pkg::OP_QUERY, -24, 3069, 0, 0);
        settle();
    endtask

    function automatic int rand_coord();
        if ($urandom_range(3) == 0)
            return int'($signed(30'($urandom())));
        return int'($urandom_range(400)) - 200;
    endfunction

    function automatic int rand_link();
        if ($urandom_range(4) == 0)
            return int'($urandom());
        return int'($urandom_range(3));
    endfunction

    // Random register settings, extremes included.
    task automatic random_config();
        case ($urandom_range(3))
            0: write_reg(nlm_pkg::REG_MAX_DISTANCE, DistMax);
            1: write_reg(nlm_pkg::REG_MAX_DISTANCE, 31'd0);
            default: write_reg(nlm_pkg::REG_MAX_DISTANCE, 31'($urandom_range(300)));
        endcase
        case ($urandom_range(3))
            0: write_reg(nlm_pkg::REG_NEAR_ENOUGH, DistMax);
            1: write_reg(nlm_pkg::REG_NEAR_ENOUGH, 31'd0);
            2: write_reg(nlm_pkg::REG_NEAR_ENOUGH, 31'd50);
            default: write_reg(nlm_pkg::REG_NEAR_ENOUGH, 31'($urandom()));
        endcase
        write_reg(nlm_pkg::REG_INDEX_BASE, 31'($urandom_range(1048576)));
    endtask

    // Small stores built from clustered loads, queries on few links, some noise.
    task automatic test_random(input int n_beats, input int pct);
        int r;
        idle_pct = pct;
        random_config();
        for (int i = 0; i < n_beats; i++)
        begin
            r = $urandom_range(99);
            if (store_count >= 24 && r < 60)
                send(nlm_pkg::OP_CLEAR, rand_coord(), rand_coord(), int'($urandom()),
                     int'($urandom()));
            else if (r < 50)
                send(nlm_pkg::OP_LOAD, rand_coord(), rand_coord(), rand_link(),
                     int'($urandom()));
            else if (r < 92)
                send(nlm_pkg::OP_QUERY, rand_coord(), rand_coord(), rand_link(),
                     int'($urandom()));
            else if (r < 96)
                send(nlm_pkg::OP_CLEAR, rand_coord(), rand_coord(), int'($urandom()),
                     int'($urandom()));
            else
                send(OP_UNUSED, rand_coord(), rand_coord(), int'($urandom()),
                     int'($urandom()));
            if (i % 40 == 39)
            begin
                settle();
                random_config();
            end
        end
        settle();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_store();
        write_reg(nlm_pkg::REG_INDEX_BASE, 31'd0);
        send(nlm_pkg::OP_CLEAR, 0, 0, 0, 0);
        settle();
        test_random(95, 13);
        test_random(95, 87);
        test_random(100, 0);
        repeat (50) @(posedge clk);
        if (pending_matches.size() != 0)
            report($sformatf("%0d matches never arrived", pending_matches.size()));
        $display("ran %0d beats, %0d queries, %0d match beats checked in %0d cycles",
                 beat_count, query_count, match_count, cycle_count);
        $display("covered full store, register extremes, ties, early stop and idle gaps");
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
